[rtl/first_fit_heap_allocator_top_assert.svh]
// assertion macros shared by the allocator modules
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FFHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ffha_pkg.sv]
// types and constants of the first-fit heap allocator
package ffha_pkg;

  localparam int ADDR_W = 7;   // widest heap is 128 bytes
  localparam int PTR_W  = 9;   // walk pointer can step past the end of the heap

  localparam logic [2:0] FN_ALLOC  = 3'd0;
  localparam logic [2:0] FN_FREE   = 3'd1;
  localparam logic [2:0] FN_WRITE  = 3'd2;
  localparam logic [2:0] FN_READ   = 3'd3;
  localparam logic [2:0] FN_HEADER = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
  localparam logic [2:0] ST_NO_SPACE  = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_TOO_BIG   = 3'd4;

  localparam logic [6:0] READ_CAP = 7'd64;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] req_size;
    logic [7:0] target_id;
    logic [7:0] fill_byte;
    logic [6:0] byte_count;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  new_id;
    logic [7:0]  read_byte;
    logic [15:0] header_word;
    logic        last;
  } res_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
  } mem_req_t;

endpackage

[rtl/ffha_stream_if.sv]
// valid/ready channel carrying one payload item per transfer
interface ffha_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

[rtl/first_fit_heap_allocator_top.sv]
// top level of the first-fit heap allocator
// First-fit allocator over a byte heap of HEAP_BYTES bytes held in one synchronous
// memory with two read ports and one write port. One request is worked at a time;
// in_ch is ready only while the sequencer is idle, and a finished result waits in
// the output register while the next request is taken. The walk over block headers
// reads the header of each block visited, then checks it. After the match, allocate
// writes the id byte, then the size byte, then the remainder's header when it
// splits; free rewrites the size byte, write stores the filled bytes one by one
// and then finishes, and a header query goes straight to its result; read fetches
// each byte and then takes it in, reads the next size at each block boundary
// crossed, and closes the stream at the end. Each request other than a read ends by
// loading its final result, and any cycle in which that result or a read byte finds
// the output register still full is a stall.
module first_fit_heap_allocator_top #(
  parameter int HEAP_BYTES = 128
) (
  input logic    clk,
  input logic    rst_n,
  ffha_stream_if.sink   in_ch,
  ffha_stream_if.source out_ch
);

  ffha_pkg::mem_req_t mreq;
  logic [7:0]         rd_data_a, rd_data_b;
  ffha_pkg::req_t     in_payload;
  ffha_pkg::res_t     out_payload;
  logic               in_ready, out_valid;

  assign in_payload     = in_ch.payload;
  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_payload;

  ffha_heap_mem #(.HEAP_BYTES(HEAP_BYTES)) u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (mreq),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  ffha_ctrl #(.HEAP_BYTES(HEAP_BYTES)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_payload  (in_payload),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_payload (out_payload),
    .out_ready   (out_ch.ready),
    .mreq        (mreq),
    .rd_data_a   (rd_data_a),
    .rd_data_b   (rd_data_b)
  );

endmodule

[rtl/ffha_heap_mem.sv]
// heap byte store: one write port, two registered read ports, per-byte valid bits
`include "first_fit_heap_allocator_top_assert.svh"
module ffha_heap_mem #(
  parameter int HEAP_BYTES = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ffha_pkg::mem_req_t  req,
  output logic [7:0]          rd_data_a,
  output logic [7:0]          rd_data_b
);

  localparam int AW = $clog2(HEAP_BYTES);
  localparam logic [7:0] INIT_SZ = 8'(((HEAP_BYTES - 2) * 2) % 256);

  logic [7:0]            mem [HEAP_BYTES];
  logic [HEAP_BYTES-1:0] valid_r;
  logic [7:0]            raw_a_r, raw_b_r;
  logic                  vld_a_r, vld_b_r, one_a_r, one_b_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      raw_a_r <= mem[req.rd_addr_a[AW-1:0]];
      raw_b_r <= mem[req.rd_addr_b[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      one_a_r <= 1'b0;
      one_b_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr[AW-1:0]] <= 1'b1;
      end
      if (req.rd_en) begin
        vld_a_r <= valid_r[req.rd_addr_a[AW-1:0]];
        vld_b_r <= valid_r[req.rd_addr_b[AW-1:0]];
        one_a_r <= (req.rd_addr_a == ffha_pkg::ADDR_W'(1));
        one_b_r <= (req.rd_addr_b == ffha_pkg::ADDR_W'(1));
      end
    end
  end

  // a byte never written reads as the reset image of the heap
  assign rd_data_a = vld_a_r ? raw_a_r : (one_a_r ? INIT_SZ : 8'd0);
  assign rd_data_b = vld_b_r ? raw_b_r : (one_b_r ? INIT_SZ : 8'd0);

  `FFHA_ASSERT_NOW(a_rd_in_heap, req.rd_en, (int'(req.rd_addr_a) < HEAP_BYTES) && (int'(req.rd_addr_b) < HEAP_BYTES), "read address beyond heap")
  `FFHA_ASSERT_NOW(a_wr_in_heap, req.wr_en, int'(req.wr_addr) < HEAP_BYTES, "write address beyond heap")
  `FFHA_ASSERT_NOW(a_no_rw_clash, req.wr_en && req.rd_en, (req.wr_addr != req.rd_addr_a) && (req.wr_addr != req.rd_addr_b), "read and write of one byte together")

endmodule

[rtl/ffha_ctrl.sv]
// request sequencer: header walk, allocate, free, write, read and header query
`include "first_fit_heap_allocator_top_assert.svh"
module ffha_ctrl #(
  parameter int HEAP_BYTES = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  ffha_pkg::req_t      in_payload,
  output logic                in_ready,
  output logic                out_valid,
  output ffha_pkg::res_t      out_payload,
  input  logic                out_ready,
  output ffha_pkg::mem_req_t  mreq,
  input  logic [7:0]          rd_data_a,
  input  logic [7:0]          rd_data_b
);

  localparam int PW = ffha_pkg::PTR_W;
  localparam int AW = ffha_pkg::ADDR_W;
  localparam logic [PW-1:0] HB_P   = PW'(HEAP_BYTES);
  localparam logic [7:0]    MAX_RQ = 8'(HEAP_BYTES - 2);

  typedef enum logic [3:0] {
    S_IDLE, S_WALK_RD, S_WALK_CHK, S_A_ID, S_A_SZ, S_A_SPLIT, S_FREE, S_WR,
    S_R_BLK, S_R_SZ, S_R_DAT, S_R_END, S_RESP
  } state_t;

  state_t          state_r, state_nxt;
  ffha_pkg::req_t  req_r, req_nxt;
  logic [PW-1:0]   p_r, p_nxt;
  logic [7:0]      s_r, s_nxt;
  logic [7:0]      i_r, i_nxt;
  logic [6:0]      left_r, left_nxt;
  logic [6:0]      psz_r, psz_nxt;
  logic            inrng_r, inrng_nxt;
  logic            pend_r, pend_nxt;
  logic [7:0]      pend_byte_r, pend_byte_nxt;
  logic [2:0]      status_r, status_nxt;
  logic [7:0]      new_id_r, new_id_nxt;
  logic [15:0]     header_r, header_nxt;
  logic [7:0]      next_id_r, next_id_nxt;
  logic            out_valid_r, out_valid_nxt;
  ffha_pkg::res_t  out_r, out_nxt;

  logic            out_free, push, match, split;
  ffha_pkg::res_t  push_res;
  logic [PW-1:0]   addr, step;
  logic [6:0]      sz7, cur;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_payload = out_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    p_nxt         = p_r;
    s_nxt         = s_r;
    i_nxt         = i_r;
    left_nxt      = left_r;
    psz_nxt       = psz_r;
    inrng_nxt     = inrng_r;
    pend_nxt      = pend_r;
    pend_byte_nxt = pend_byte_r;
    status_nxt    = status_r;
    new_id_nxt    = new_id_r;
    header_nxt    = header_r;
    next_id_nxt   = next_id_r;
    push          = 1'b0;
    push_res      = '0;
    mreq          = '0;
    sz7           = rd_data_a[7:1];
    cur           = s_r[7:1];
    match         = 1'b0;
    split         = 1'b0;
    addr          = '0;
    step          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_payload;
          p_nxt      = PW'(1);
          status_nxt = ffha_pkg::ST_OK;
          new_id_nxt = '0;
          header_nxt = '0;
          if (in_payload.func > ffha_pkg::FN_HEADER) begin
            status_nxt = ffha_pkg::ST_BAD_SIZE;
            state_nxt  = S_RESP;
          end else if (in_payload.func == ffha_pkg::FN_ALLOC &&
                       (in_payload.req_size == 8'd0 || in_payload.req_size > MAX_RQ)) begin
            status_nxt = ffha_pkg::ST_BAD_SIZE;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_WALK_RD;
          end
        end
      end
      S_WALK_RD: begin
        if (p_r >= HB_P) begin
          status_nxt = (req_r.func == ffha_pkg::FN_ALLOC) ? ffha_pkg::ST_NO_SPACE
                                                           : ffha_pkg::ST_NOT_FOUND;
          state_nxt  = S_RESP;
        end else begin
          mreq.rd_en     = 1'b1;
          mreq.rd_addr_a = AW'(p_r);
          mreq.rd_addr_b = AW'(p_r - PW'(1));
          state_nxt      = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        if (req_r.func == ffha_pkg::FN_ALLOC) begin
          match = !rd_data_a[0] && ({1'b0, sz7} >= req_r.req_size);
        end else begin
          match = rd_data_a[0] && (rd_data_b == req_r.target_id);
        end
        if (match) begin
          s_nxt = rd_data_a;
          i_nxt = 8'd1;
          case (req_r.func)
            ffha_pkg::FN_ALLOC: state_nxt = S_A_ID;
            ffha_pkg::FN_FREE:  state_nxt = S_FREE;
            ffha_pkg::FN_WRITE: begin
              if (sz7 < req_r.byte_count) begin
                status_nxt = ffha_pkg::ST_TOO_BIG;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_WR;
              end
            end
            ffha_pkg::FN_READ: begin
              left_nxt  = (req_r.byte_count > ffha_pkg::READ_CAP) ? ffha_pkg::READ_CAP
                                                                 : req_r.byte_count;
              psz_nxt   = sz7;
              state_nxt = S_R_BLK;
            end
            default: begin
              header_nxt = {rd_data_b, rd_data_a};
              state_nxt  = S_RESP;
            end
          endcase
        end else begin
          p_nxt     = p_r + PW'(sz7) + PW'(2);
          state_nxt = S_WALK_RD;
        end
      end
      S_A_ID: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = AW'(p_r - PW'(1));
        mreq.wr_data = next_id_r;
        new_id_nxt   = next_id_r;
        next_id_nxt  = next_id_r + 8'd1;
        state_nxt    = S_A_SZ;
      end
      S_A_SZ: begin
        // split only when more than a header's worth is left over
        split        = PW'(cur) > (PW'(req_r.req_size) + PW'(2));
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = AW'(p_r);
        mreq.wr_data = split ? {req_r.req_size[6:0], 1'b1} : {cur, 1'b1};
        state_nxt    = split ? S_A_SPLIT : S_RESP;
      end
      S_A_SPLIT: begin
        addr         = p_r + PW'(req_r.req_size) + PW'(2);
        mreq.wr_en   = (addr < HB_P);
        mreq.wr_addr = AW'(addr);
        mreq.wr_data = {7'(cur - req_r.req_size[6:0] - 7'd2), 1'b0};
        state_nxt    = S_RESP;
      end
      S_FREE: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = AW'(p_r);
        mreq.wr_data = {s_r[7:1], 1'b0};
        state_nxt    = S_RESP;
      end
      S_WR: begin
        if (i_r > {1'b0, req_r.byte_count}) begin
          state_nxt = S_RESP;
        end else begin
          addr         = p_r + PW'(i_r);
          mreq.wr_en   = (addr < HB_P);
          mreq.wr_addr = AW'(addr);
          mreq.wr_data = req_r.fill_byte;
          i_nxt        = i_r + 8'd1;
        end
      end
      S_R_BLK: begin
        if (left_r == 7'd0) begin
          state_nxt = S_R_END;
        end else if (i_r > {1'b0, psz_r}) begin
          // block done, move on to the header of the next one
          step  = p_r + PW'(psz_r) + PW'(2);
          p_nxt = step;
          if (step >= HB_P) begin
            state_nxt = S_R_END;
          end else begin
            mreq.rd_en     = 1'b1;
            mreq.rd_addr_a = AW'(step);
            mreq.rd_addr_b = AW'(step);
            state_nxt      = S_R_SZ;
          end
        end else begin
          addr           = p_r + PW'(i_r);
          inrng_nxt      = (addr < HB_P);
          mreq.rd_en     = (addr < HB_P);
          mreq.rd_addr_a = AW'(addr);
          mreq.rd_addr_b = AW'(addr);
          state_nxt      = S_R_DAT;
        end
      end
      S_R_SZ: begin
        psz_nxt   = sz7;
        i_nxt     = 8'd1;
        state_nxt = S_R_BLK;
      end
      S_R_DAT: begin
        // one byte held back so the final one can carry last
        if (!pend_r || out_free) begin
          if (pend_r) begin
            push               = 1'b1;
            push_res.read_byte = pend_byte_r;
          end
          pend_nxt      = 1'b1;
          pend_byte_nxt = inrng_r ? rd_data_a : 8'd0;
          left_nxt      = left_r - 7'd1;
          i_nxt         = i_r + 8'd1;
          state_nxt     = S_R_BLK;
        end
      end
      S_R_END: begin
        if (out_free) begin
          push               = 1'b1;
          push_res.read_byte = pend_r ? pend_byte_r : 8'd0;
          push_res.last      = 1'b1;
          pend_nxt           = 1'b0;
          state_nxt          = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          push                 = 1'b1;
          push_res.status      = status_r;
          push_res.new_id      = new_id_r;
          push_res.header_word = header_r;
          push_res.last        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = push ? 1'b1 : (out_valid_r && !out_ready);
    out_nxt       = push ? push_res : out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_id_r   <= 8'd1;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
    req_r       <= req_nxt;
    p_r         <= p_nxt;
    s_r         <= s_nxt;
    i_r         <= i_nxt;
    left_r      <= left_nxt;
    psz_r       <= psz_nxt;
    inrng_r     <= inrng_nxt;
    pend_byte_r <= pend_byte_nxt;
    status_r    <= status_nxt;
    new_id_r    <= new_id_nxt;
    header_r    <= header_nxt;
    out_r       <= out_nxt;
  end

  `FFHA_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_r != S_IDLE, "accepted request did not start")
  `FFHA_ASSERT_NOW(a_pend_in_read, pend_r, state_r == S_R_BLK || state_r == S_R_SZ || state_r == S_R_DAT || state_r == S_R_END, "held read byte outside a read")
  `FFHA_ASSERT_NOW(a_id_only_on_alloc, !$stable(next_id_r), $past(state_r) == S_A_ID, "id counter moved outside allocate")

endmodule

[bench/first_fit_heap_allocator_top_test.sv]
// self-checking bench for the first-fit heap allocator top level
module first_fit_heap_allocator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP = 128;
  localparam int HDR = 2;
  localparam logic [2:0] FN_BAD = 3'd5;
  localparam logic [2:0] FN_BAD_TOP = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ffha_stream_if #(.payload_t(ffha_pkg::req_t)) in_ch ();
  ffha_stream_if #(.payload_t(ffha_pkg::res_t)) out_ch ();

  first_fit_heap_allocator_top #(.HEAP_BYTES(HEAP)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #6 clk = ~clk;

  // shadow copy of the heap and id counter
  logic [7:0] heap_img[HEAP];
  logic [7:0] next_id_img;
  int live_ids[$];
  ffha_pkg::res_t expected_results[$];

  int mismatches = 0;
  int failures = 0;
  int results_seen = 0;
  int items_sent = 0;
  bit no_gaps = 1'b0;
  int hold_cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    foreach (heap_img[i]) heap_img[i] = 8'd0;
    heap_img[1] = 8'((HEAP - HDR) << 1);
    next_id_img = 8'd1;
  end

  function automatic logic [7:0] heap_get(int a);
    return (a < HEAP) ? heap_img[a] : 8'd0;
  endfunction

  function automatic void push_result(logic [2:0] st, logic [7:0] nid, logic [7:0] rb,
                                      logic [15:0] hw, logic lst);
    ffha_pkg::res_t e;
    e.status = st;
    e.new_id = nid;
    e.read_byte = rb;
    e.header_word = hw;
    e.last = lst;
    expected_results.push_back(e);
  endfunction

  // size-byte address of the first allocated block with this id, or HEAP
  function automatic int lookup_block(logic [7:0] id);
    int p;
    p = 1;
    while (p < HEAP) begin
      if (heap_img[p][0] && heap_img[p-1] == id) return p;
      p += int'(heap_img[p] >> 1) + HDR;
    end
    return HEAP;
  endfunction

  function automatic void predict_request(ffha_pkg::req_t r);
    int p, cur, req, left, psz, n;
    logic [7:0] id;
    req = int'(r.req_size);
    case (r.func)
      ffha_pkg::FN_ALLOC: begin
        if (req == 0 || req > HEAP - HDR) begin
          push_result(ffha_pkg::ST_BAD_SIZE, 8'd0, 8'd0, 16'd0, 1'b1);
          return;
        end
        p = 1;
        while (p < HEAP && (heap_img[p][0] || int'(heap_img[p] >> 1) < req))
          p += int'(heap_img[p] >> 1) + HDR;
        if (p >= HEAP) begin
          push_result(ffha_pkg::ST_NO_SPACE, 8'd0, 8'd0, 16'd0, 1'b1);
          return;
        end
        id = next_id_img;
        next_id_img = next_id_img + 8'd1;
        heap_img[p-1] = id;
        cur = int'(heap_img[p] >> 1);
        if (cur > req + HDR) begin
          heap_img[p] = 8'((req << 1) | 1);
          if (p + req + HDR < HEAP) heap_img[p + req + HDR] = 8'((cur - req - HDR) << 1);
        end else begin
          heap_img[p] = 8'((cur << 1) | 1);
        end
        live_ids.push_back(int'(id));
        push_result(ffha_pkg::ST_OK, id, 8'd0, 16'd0, 1'b1);
      end
      ffha_pkg::FN_FREE, ffha_pkg::FN_WRITE, ffha_pkg::FN_READ, ffha_pkg::FN_HEADER: begin
        p = lookup_block(r.target_id);
        if (p >= HEAP) begin
          push_result(ffha_pkg::ST_NOT_FOUND, 8'd0, 8'd0, 16'd0, 1'b1);
          return;
        end
        if (r.func == ffha_pkg::FN_FREE) begin
          heap_img[p][0] = 1'b0;
          foreach (live_ids[i]) if (live_ids[i] == int'(r.target_id)) begin
            live_ids.delete(i);
            break;
          end
          push_result(ffha_pkg::ST_OK, 8'd0, 8'd0, 16'd0, 1'b1);
        end else if (r.func == ffha_pkg::FN_WRITE) begin
          if (int'(heap_img[p] >> 1) < int'(r.byte_count)) begin
            push_result(ffha_pkg::ST_TOO_BIG, 8'd0, 8'd0, 16'd0, 1'b1);
            return;
          end
          for (int i = 1; i <= int'(r.byte_count); i++)
            if (p + i < HEAP) heap_img[p + i] = r.fill_byte;
          push_result(ffha_pkg::ST_OK, 8'd0, 8'd0, 16'd0, 1'b1);
        end else if (r.func == ffha_pkg::FN_HEADER) begin
          push_result(ffha_pkg::ST_OK, 8'd0, 8'd0, {heap_img[p-1], heap_img[p]}, 1'b1);
        end else begin
          left = (r.byte_count > ffha_pkg::READ_CAP) ? int'(ffha_pkg::READ_CAP)
                                                      : int'(r.byte_count);
          n = 0;
          // the stream runs on into the following blocks, free or not
          while (p < HEAP && left > 0) begin
            psz = int'(heap_img[p] >> 1);
            for (int i = 1; i <= psz && left > 0; i++) begin
              push_result(ffha_pkg::ST_OK, 8'd0, heap_get(p + i), 16'd0, 1'b0);
              n++;
              left--;
            end
            p += psz + HDR;
          end
          if (n == 0) push_result(ffha_pkg::ST_OK, 8'd0, 8'd0, 16'd0, 1'b1);
          else expected_results[$].last = 1'b1;
        end
      end
      default: push_result(ffha_pkg::ST_BAD_SIZE, 8'd0, 8'd0, 16'd0, 1'b1);
    endcase
  endfunction

  // receiver: random stalls, optional long hold-off, and the result check
  always @(posedge clk) begin
    ffha_pkg::res_t e, got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        results_seen++;
        if (expected_results.size() == 0) begin
          failures++;
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d id %0d byte %0d hdr %h last %0d",
                     got.status, got.new_id, got.read_byte, got.header_word, got.last);
        end else begin
          e = expected_results.pop_front();
          if (got.status !== e.status || got.new_id !== e.new_id ||
              got.read_byte !== e.read_byte || got.header_word !== e.header_word ||
              got.last !== e.last) begin
            failures++;
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp st %0d id %0d byte %0d hdr %h last %0d",
                        " / got st %0d id %0d byte %0d hdr %h last %0d"},
                       e.status, e.new_id, e.read_byte, e.header_word, e.last,
                       got.status, got.new_id, got.read_byte, got.header_word, got.last);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 21);
      end
    end
  end

  task automatic send_request(ffha_pkg::req_t r);
    if (!no_gaps && $urandom_range(0, 99) < 21) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= r;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    predict_request(r);
    items_sent++;
  endtask

  task automatic issue(logic [2:0] fn, int sz, int tid, int fill, int cnt);
    ffha_pkg::req_t r;
    r.func = fn;
    r.req_size = 8'(sz);
    r.target_id = 8'(tid);
    r.fill_byte = 8'(fill);
    r.byte_count = 7'(cnt);
    send_request(r);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_directed();
    issue(ffha_pkg::FN_ALLOC, 0, 0, 0, 0);
    issue(ffha_pkg::FN_ALLOC, 127, 0, 0, 0);
    issue(ffha_pkg::FN_ALLOC, 255, 255, 255, 127);
    issue(FN_BAD, 4, 1, 0, 0);
    issue(FN_BAD_TOP, 4, 1, 0, 0);
    issue(ffha_pkg::FN_ALLOC, 126, 0, 0, 0);          // whole heap, no split
    issue(ffha_pkg::FN_ALLOC, 1, 0, 0, 0);            // no space left
    issue(ffha_pkg::FN_HEADER, 0, 1, 0, 0);
    issue(ffha_pkg::FN_WRITE, 0, 1, 255, 126);
    issue(ffha_pkg::FN_WRITE, 0, 1, 0, 127);          // larger than payload
    issue(ffha_pkg::FN_READ, 0, 1, 0, 127);           // clamped read
    issue(ffha_pkg::FN_READ, 0, 1, 0, 0);
    issue(ffha_pkg::FN_HEADER, 0, 85, 0, 0);
    issue(ffha_pkg::FN_FREE, 0, 1, 0, 0);
    issue(ffha_pkg::FN_FREE, 0, 1, 0, 0);             // already free
    issue(ffha_pkg::FN_ALLOC, 10, 0, 0, 0);           // split, remainder keeps old id byte
    issue(ffha_pkg::FN_ALLOC, 113, 0, 0, 0);          // spare of one byte, no split
    issue(ffha_pkg::FN_ALLOC, 111, 0, 0, 0);
    issue(ffha_pkg::FN_WRITE, 0, 2, 8'h5a, 10);
    issue(ffha_pkg::FN_WRITE, 0, 2, 0, 0);
    issue(ffha_pkg::FN_READ, 0, 2, 0, 64);            // runs into the next block
    issue(ffha_pkg::FN_FREE, 0, 2, 0, 0);
    issue(ffha_pkg::FN_READ, 0, 3, 0, 64);            // ends inside the block
    issue(ffha_pkg::FN_FREE, 0, 3, 0, 0);
    wait_idle();
  endtask

  task automatic test_random(int count);
    int sel, tid;
    for (int k = 0; k < count; k++) begin
      no_gaps = (k >= count / 2 && k < count / 2 + 30);
      sel = $urandom_range(0, 99);
      tid = (live_ids.size() != 0 && $urandom_range(0, 99) < 85) ?
            live_ids[$urandom_range(0, live_ids.size() - 1)] : $urandom_range(0, 255);
      if (sel < 30)
        issue(ffha_pkg::FN_ALLOC, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
              : $urandom_range(1, 24), 0, 0, 0);
      else if (sel < 45) issue(ffha_pkg::FN_FREE, 0, tid, 0, 0);
      else if (sel < 65)
        issue(ffha_pkg::FN_WRITE, 0, tid, $urandom_range(0, 255),
              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12));
      else if (sel < 80) issue(ffha_pkg::FN_READ, 0, tid, 0, $urandom_range(0, 127));
      else if (sel < 95) issue(ffha_pkg::FN_HEADER, 0, tid, 0, 0);
      else issue(3'($urandom_range(0, 7)), $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 127));
    end
    no_gaps = 1'b0;
    wait_idle();
  endtask

  // one-byte blocks are taken, queried and given back
  task automatic test_id_wrap();
    no_gaps = 1'b1;
    for (int k = 0; k < 4; k++) begin
      issue(ffha_pkg::FN_ALLOC, 1, 0, 0, 0);
      issue(ffha_pkg::FN_HEADER, 0, live_ids[$], 0, 0);
      issue(ffha_pkg::FN_FREE, 0, live_ids[$], 0, 0);
    end
    no_gaps = 1'b0;
    wait_idle();
  endtask

  // results held back while long reads keep coming
  task automatic test_backpressure();
    issue(ffha_pkg::FN_ALLOC, 40, 0, 0, 0);
    wait_idle();
    hold_cycles = 400;
    for (int k = 0; k < 6; k++) issue(ffha_pkg::FN_READ, 0, live_ids[$], 0, 64);
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(140);
    test_id_wrap();
    test_backpressure();
    if (expected_results.size() != 0) failures++;
    $display("covered %0d requests and %0d result transfers: all functions,",
             items_sent, results_seen);
    $display("splits, clamped and truncated reads, and a long output stall");
    if (failures == 0) begin
      $display("[first_fit_heap_allocator_top] OK");
    end else begin
      $display("%0d failures", failures);
      $display("[first_fit_heap_allocator_top] ERROR");
    end
    $finish;
  end

  initial begin
    #36_000_000;
    $display("[first_fit_heap_allocator_top] ERROR");
    $finish;
  end
endmodule

[first_fit_heap_allocator_top.f]
+incdir+rtl
rtl/ffha_pkg.sv
rtl/ffha_stream_if.sv
rtl/ffha_heap_mem.sv
rtl/ffha_ctrl.sv
rtl/first_fit_heap_allocator_top.sv
bench/first_fit_heap_allocator_top_test.sv
